// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the per-processor end time table.
// Needs nothing else; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that, once seen, forces a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pet_pkg.sv =====
// Package for the per-processor end time table: transaction payload types,
// status codes and saturation limits. Depends on nothing.
package pet_pkg;

  localparam int SLOT_INDEX_W = 4;

  localparam logic [31:0] END_MAX   = 32'hFFFF_FFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  typedef struct packed {
    logic [15:0] processor_number;
    logic [15:0] job_tag;
    logic [15:0] job_duration;
  } job_t;

  typedef struct packed {
    logic [15:0]             out_processor;
    logic [15:0]             out_tag;
    logic [15:0]             out_duration;
    logic [31:0]             end_time;
    logic [15:0]             job_position;
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic                    new_processor;
    logic [1:0]              status;
  } result_t;

endpackage

// ===== hdl/pet_table.sv =====
// Slot table of the per-processor end time table: key compare, slot
// allocation, end time accumulation and job counting. Uses pet_pkg and
// assert_macros.svh.
`include "assert_macros.svh"

module pet_table #(
  parameter int SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  pet_pkg::job_t    job,
  output pet_pkg::result_t result
);
  import pet_pkg::*;

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int USED_W = $clog2(SLOTS + 1);
  localparam int WIDE_W = (IDX_W > SLOT_INDEX_W) ? IDX_W : SLOT_INDEX_W;

  logic [SLOTS-1:0]  slot_valid;
  logic [15:0]       slot_processor [SLOTS];
  logic [31:0]       slot_end_time  [SLOTS];
  logic [15:0]       slot_job_count [SLOTS];
  logic [USED_W-1:0] slots_used;

  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic              table_full;
  logic              fresh;
  logic [IDX_W-1:0]  sel_idx;
  logic [31:0]       base_end;
  logic [32:0]       sum;
  logic              saturated;
  logic [31:0]       end_val;
  logic [15:0]       pos;
  logic [15:0]       count_next;
  logic [WIDE_W-1:0] wide_idx;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && (slot_processor[i] == job.processor_number)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign table_full = !hit && (slots_used == USED_W'(SLOTS));
  assign fresh      = !hit && !table_full;
  assign sel_idx    = hit ? hit_idx : slots_used[IDX_W-1:0];

  assign base_end   = fresh ? 32'd0 : slot_end_time[sel_idx];
  assign pos        = fresh ? 16'd0 : slot_job_count[sel_idx];
  assign sum        = 33'(base_end) + 33'(job.job_duration);
  assign saturated  = sum[32];
  assign end_val    = saturated ? END_MAX : sum[31:0];
  assign count_next = (pos == COUNT_MAX) ? pos : pos + 16'd1;
  assign wide_idx   = WIDE_W'(sel_idx);

  always_comb begin
    result.out_processor = job.processor_number;
    result.out_tag       = job.job_tag;
    result.out_duration  = job.job_duration;
    if (table_full) begin
      result.end_time      = 32'd0;
      result.job_position  = 16'd0;
      result.slot_index    = '0;
      result.new_processor = 1'b0;
      result.status        = STATUS_FULL;
    end else begin
      result.end_time      = end_val;
      result.job_position  = pos;
      result.slot_index    = wide_idx[SLOT_INDEX_W-1:0];
      result.new_processor = fresh;
      result.status        = saturated ? STATUS_SATURATED : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slots_used <= '0;
    end else if (fire && !table_full) begin
      slot_valid[sel_idx] <= 1'b1;
      if (fresh) begin
        slots_used <= slots_used + USED_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !table_full) begin
      slot_processor[sel_idx] <= job.processor_number;
      slot_end_time[sel_idx]  <= end_val;
      slot_job_count[sel_idx] <= count_next;
    end
  end

  `ASSERT_SYNC(a_used_bound, clk, rst, slots_used <= USED_W'(SLOTS), "slot count beyond table size")
  `ASSERT_SYNC(a_valid_count, clk, rst, $countones(slot_valid) == int'(slots_used), "valid slots disagree with slot count")
  `ASSERT_NEXT(a_full_frozen, clk, rst, fire && table_full, $stable(slots_used) && $stable(slot_valid), "table changed on a full miss")
  `ASSERT_NEXT(a_alloc_step, clk, rst, fire && fresh, slots_used == $past(slots_used) + USED_W'(1), "allocation did not advance slot count")

endmodule

// ===== hdl/per_processor_end_time_table_top.sv =====
// Top level of the per-processor end time table: input register, slot
// table and result register. Uses pet_pkg and pet_table.
//
//   Channel   Handshake                  Payload
//   job       job_valid / job_ready      job_data    (pet_pkg::job_t)
//   result    result_valid / result_ready result_data (pet_pkg::result_t)
//
// A job is taken into the input register, looked up and accounted as it leaves
// it, and its result is loaded into the result register at that same edge.
// The slot compare and the end time add form the single path between the two
// registers, so one job is accepted every cycle while results are taken.
// Reset clears the slot valid bits and the slot count.
// A stalled result holds the input register, which then holds job_ready low.
module per_processor_end_time_table_top #(
  parameter int SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  pet_pkg::job_t    job_data,
  output logic             result_valid,
  input  logic             result_ready,
  output pet_pkg::result_t result_data
);
  import pet_pkg::*;

  logic    job_full;
  job_t    job_q;
  logic    result_full;
  result_t result_q;
  result_t result_next;
  logic    advance;

  assign advance      = job_full && (!result_full || result_ready);
  assign job_ready    = !job_full || advance;
  assign result_valid = result_full;
  assign result_data  = result_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_full <= 1'b0;
    end else if (job_valid && job_ready) begin
      job_full <= 1'b1;
    end else if (advance) begin
      job_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job_q <= job_data;
    end
  end

  pet_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .job    (job_q),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_full <= 1'b0;
    end else if (advance) begin
      result_full <= 1'b1;
    end else if (result_ready) begin
      result_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result_next;
    end
  end

endmodule
